@@ sv/bwlv_pkg.sv @@
// Shared widths, reset values and filter coefficients for the low-pass/velocity block.
package bwlv_pkg;

  localparam int PosW            = 32;  // Q16.16 position and velocity fields
  localparam int SrW             = 16;  // sample rate register
  localparam int HistW           = 48;  // filter output history entries
  localparam int FilterOrder     = 4;
  localparam int FracBitsDefault = 16;

  localparam logic [SrW-1:0] SampleRateReset = SrW'(100);

  // Q2.30 constants: reciprocal of the filter gain and the feedback taps (magnitudes)
  localparam logic [31:0] InvGainQ30 = 32'd261359796;
  localparam logic [31:0] FbCoefQ30 [FilterOrder] = '{
    32'd64248658, 32'd416143486, 32'd1161122937, 32'd1466499822
  };

  // Round a Q2.30 constant half up to frac fraction bits.
  function automatic logic [31:0] qcoef(input logic [31:0] c30, input int frac);
    logic [32:0] sum;
    sum = {1'b0, c30} + (33'd1 << (29 - frac));
    return 32'(sum >> (30 - frac));
  endfunction

endpackage

@@ sv/bwlv_in_if.sv @@
// Input channel: one position sample per transaction.
interface bwlv_in_if;
  import bwlv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

@@ sv/bwlv_out_if.sv @@
// Output channel: pass-through x, filtered y and x velocity per transaction.
interface bwlv_out_if;
  import bwlv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] out_x;
  logic signed [PosW-1:0] filtered_y;
  logic signed [PosW-1:0] velocity_x;

  modport source (output valid, output out_x, output filtered_y, output velocity_x,
                  input ready);
  modport sink   (input valid, input out_x, input filtered_y, input velocity_x,
                  output ready);
endinterface

@@ sv/bwlv_mulq.sv @@
// Signed value times constant coefficient, rounded half away from zero.
module bwlv_mulq #(
  parameter int          AW        = 32,
  parameter int          FRAC_BITS = bwlv_pkg::FracBitsDefault,
  parameter logic [31:0] COEF_Q30  = bwlv_pkg::InvGainQ30
) (
  input  logic signed [AW-1:0] a_i,
  output logic signed [AW+1:0] p_o
);
  import bwlv_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam int PW = AW + CW;
  localparam logic [CW-1:0] Coef = CW'(qcoef(COEF_Q30, FRAC_BITS));
  localparam logic [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);

  logic          neg;
  logic [AW-1:0] ua;
  logic [AW-1:0] mag;
  logic [PW-1:0] prod;
  logic [PW-1:0] rsum;
  logic [AW:0]   rmag;

  always_comb begin
    neg  = a_i[AW-1];
    ua   = $unsigned(a_i);
    mag  = neg ? (~ua + AW'(1)) : ua;
    prod = {{CW{1'b0}}, mag} * {{AW{1'b0}}, Coef};
    rsum = prod + Half;  // cannot carry out: mag <= 2^(AW-1), Coef < 2^CW
    rmag = rsum[PW-1:FRAC_BITS];
    p_o  = neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

endmodule

@@ sv/bwlv_iir.sv @@
// Fourth-order Butterworth low-pass on y: scaling, binomial taps, feedback and history.
module bwlv_iir #(
  parameter int FRAC_BITS = bwlv_pkg::FracBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic signed [bwlv_pkg::PosW-1:0] pos_y_i,
  output logic signed [bwlv_pkg::PosW-1:0] filtered_y_o
);
  import bwlv_pkg::*;

  localparam int SinW = PosW + 2;
  localparam int FbW  = HistW + 2;
  localparam int AccW = HistW + 5;

  localparam logic signed [HistW-1:0] H48Max = $signed({1'b0, {(HistW-1){1'b1}}});
  localparam logic signed [HistW-1:0] H48Min = $signed({1'b1, {(HistW-1){1'b0}}});
  localparam logic signed [PosW-1:0]  S32Max = $signed({1'b0, {(PosW-1){1'b1}}});
  localparam logic signed [PosW-1:0]  S32Min = $signed({1'b1, {(PosW-1){1'b0}}});

  logic signed [SinW-1:0]  s_q [FilterOrder];
  logic signed [HistW-1:0] y_q [FilterOrder];
  logic signed [SinW-1:0]  sin_new;
  logic signed [FbW-1:0]   fb [FilterOrder];
  logic signed [AccW-1:0]  acc;
  logic signed [HistW-1:0] acc_h;

  bwlv_mulq #(.AW(PosW), .FRAC_BITS(FRAC_BITS), .COEF_Q30(InvGainQ30)) u_scale (
    .a_i (pos_y_i),
    .p_o (sin_new)
  );

  for (genvar g = 0; g < FilterOrder; g++) begin : g_fb
    bwlv_mulq #(.AW(HistW), .FRAC_BITS(FRAC_BITS), .COEF_Q30(FbCoefQ30[g])) u_fb (
      .a_i (y_q[g]),
      .p_o (fb[g])
    );
  end

  always_comb begin
    acc = AccW'(s_q[0]) + AccW'(sin_new)
        + ((AccW'(s_q[1]) + AccW'(s_q[3])) <<< 2)
        + (AccW'(s_q[2]) <<< 2) + (AccW'(s_q[2]) <<< 1)
        - AccW'(fb[0]) - AccW'(fb[1]) - AccW'(fb[2]) - AccW'(fb[3]);

    if (acc[AccW-1:HistW-1] == '0 || acc[AccW-1:HistW-1] == '1) begin
      acc_h = acc[HistW-1:0];
    end else begin
      acc_h = acc[AccW-1] ? H48Min : H48Max;
    end

    if (acc[AccW-1:PosW-1] == '0 || acc[AccW-1:PosW-1] == '1) begin
      filtered_y_o = acc[PosW-1:0];
    end else begin
      filtered_y_o = acc[AccW-1] ? S32Min : S32Max;
    end
  end

  // scaled input stays far below 48 bits, so it is stored without clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FilterOrder; i++) begin
        s_q[i] <= '0;
        y_q[i] <= '0;
      end
    end else if (adv_i) begin
      for (int i = 0; i < FilterOrder - 1; i++) begin
        s_q[i] <= s_q[i+1];
        y_q[i] <= y_q[i+1];
      end
      s_q[FilterOrder-1] <= sin_new;
      y_q[FilterOrder-1] <= acc_h;
    end
  end

endmodule

@@ sv/bwlv_vel.sv @@
// x velocity: first difference times sample rate, averaged with the previous one.
module bwlv_vel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic signed [bwlv_pkg::PosW-1:0] pos_x_i,
  input  logic        [bwlv_pkg::SrW-1:0]  sample_rate_i,
  output logic signed [bwlv_pkg::PosW-1:0] velocity_x_o
);
  import bwlv_pkg::*;

  localparam int DiffW = PosW + 1;
  localparam int ProdW = DiffW + SrW + 1;

  localparam logic signed [PosW-1:0] S32Max = $signed({1'b0, {(PosW-1){1'b1}}});
  localparam logic signed [PosW-1:0] S32Min = $signed({1'b1, {(PosW-1){1'b0}}});

  logic signed [PosW-1:0]  prev_x_q;
  logic signed [PosW-1:0]  prev_rate_q;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [PosW-1:0]  rate;
  logic signed [DiffW-1:0] sum;
  logic signed [DiffW-1:0] sum_adj;

  always_comb begin
    diff = DiffW'(pos_x_i) - DiffW'(prev_x_q);
    prod = ProdW'(diff) * ProdW'($signed({1'b0, sample_rate_i}));
    if (prod[ProdW-1:PosW-1] == '0 || prod[ProdW-1:PosW-1] == '1) begin
      rate = prod[PosW-1:0];
    end else begin
      rate = prod[ProdW-1] ? S32Min : S32Max;
    end
    sum = DiffW'(rate) + DiffW'(prev_rate_q);
    // halve toward zero: bias negative sums by one before the shift
    sum_adj = sum + DiffW'(sum[DiffW-1]);
    velocity_x_o = sum_adj[DiffW-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_rate_q <= '0;
    end else if (adv_i) begin
      prev_x_q    <= pos_x_i;
      prev_rate_q <= rate;
    end
  end

endmodule

@@ sv/butterworth_lowpass_and_velocity.sv @@
// Top level: input register, filter and velocity datapath, result register.
// Usage:
//   in_i  carries one Q16.16 position sample (pos_x, pos_y) per transaction,
//         taken at a clock edge with valid and ready both high.
//   out_o carries one result per sample: out_x (pos_x unchanged), filtered_y
//         (4th-order Butterworth low-pass of pos_y, saturated) and velocity_x
//         (two-sample averaged x difference times the sample rate, saturated).
//   cfg_we_i/cfg_wdata_i write the 16-bit sample rate; write only while idle.
// Timing: a sample waits in the input register, where the filter
//   and velocity logic read it together with their history, and the result
//   is registered once the result register is free or being read; that
//   raises out_o.valid. Throughput is one sample per cycle while out_o.ready
//   is high, set by the single filter pass needing the previous output first.
// Reset clears the filter histories, the previous x and rate, and sets
//   the sample rate to 100. When the receiver stalls, the result register
//   holds and the input register keeps its sample, or takes one more if it
//   was empty; after that in_i.ready stays low until out_o.ready returns.
module butterworth_lowpass_and_velocity #(
  parameter int FRAC_BITS = bwlv_pkg::FracBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bwlv_pkg::SrW-1:0]      cfg_wdata_i,
  bwlv_in_if.sink                       in_i,
  bwlv_out_if.source                    out_o
);
  import bwlv_pkg::*;

  logic                   in_v_q;
  logic signed [PosW-1:0] px_q;
  logic signed [PosW-1:0] py_q;
  logic [SrW-1:0]         sample_rate_q;
  logic                   out_v_q;
  logic signed [PosW-1:0] out_x_q;
  logic signed [PosW-1:0] fy_q;
  logic signed [PosW-1:0] vx_q;
  logic signed [PosW-1:0] fy_d;
  logic signed [PosW-1:0] vx_d;
  logic                   fire;
  logic                   in_accept;

  assign fire      = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || fire;
  assign in_accept = in_i.valid && in_i.ready;

  bwlv_iir #(.FRAC_BITS(FRAC_BITS)) u_iir (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (fire),
    .pos_y_i      (py_q),
    .filtered_y_o (fy_d)
  );

  bwlv_vel u_vel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (fire),
    .pos_x_i       (px_q),
    .sample_rate_i (sample_rate_q),
    .velocity_x_o  (vx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SampleRateReset;
    end else if (cfg_we_i) begin
      sample_rate_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_v_q <= 1'b1;
      end else if (fire) begin
        in_v_q <= 1'b0;
      end
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      px_q <= in_i.pos_x;
      py_q <= in_i.pos_y;
    end
    if (fire) begin
      out_x_q <= px_q;
      fy_q    <= fy_d;
      vx_q    <= vx_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.out_x      = out_x_q;
  assign out_o.filtered_y = fy_q;
  assign out_o.velocity_x = vx_q;

endmodule

@@ tb/bwlv_tb_pkg.sv @@
// Scoreboard for the low-pass/velocity testbench: predicts each result and checks it.
package bwlv_tb_pkg;

  localparam int FracBits = 16;
  localparam int HistDepth = 4;

  localparam longint S48Max = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48Min = -S48Max - 1;
  localparam longint S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32Min = -S32Max - 1;

  typedef logic signed [bwlv_pkg::PosW-1:0] q16_t;

  typedef struct packed {
    q16_t x;
    q16_t fy;
    q16_t vx;
  } pose_t;

  // Q2.30 constant -> unsigned coefficient with FracBits fraction bits, rounded half up
  function automatic longint unsigned q30_to_coef(input longint unsigned c30);
    return (c30 + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
  endfunction

  localparam longint unsigned InvGainCoef = q30_to_coef(261359796);
  localparam longint unsigned FbCoef0     = q30_to_coef(64248658);
  localparam longint unsigned FbCoef1     = q30_to_coef(416143486);
  localparam longint unsigned FbCoef2     = q30_to_coef(1161122937);
  localparam longint unsigned FbCoef3     = q30_to_coef(1466499822);

  class lowpass_velocity_scoreboard;
    longint      scaled_y_hist[HistDepth];
    longint      filt_y_hist[HistDepth];
    longint      last_x;
    longint      last_rate;
    int unsigned rate_hz;
    pose_t       expected_poses[$];
    int          errors;
    int          checked;
    int          filt_sats;
    int          rate_sats;

    function new();
      for (int i = 0; i < HistDepth; i++) begin
        scaled_y_hist[i] = 0;
        filt_y_hist[i] = 0;
      end
      last_x = 0;
      last_rate = 0;
      rate_hz = 100;
      errors = 0;
      checked = 0;
      filt_sats = 0;
      rate_sats = 0;
    endfunction

    function void set_rate(input int unsigned r);
      rate_hz = r & 32'hFFFF;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    static function longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // magnitude times coefficient, rounded half away from zero, sign restored
    static function longint round_mul(input longint a, input longint unsigned coef);
      logic [63:0] mag;
      logic [79:0] prod;
      bit          neg;
      neg = (a < 0);
      mag = neg ? 64'(-a) : 64'(a);
      prod = {16'd0, mag} * {16'd0, coef};
      prod = (prod + (80'd1 << (FracBits - 1))) >> FracBits;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // accepted input transaction: advance the filter and velocity state
    function void note_sample(input q16_t px, input q16_t py);
      longint s_new;
      longint acc;
      longint rate;
      longint vel;
      pose_t  r;
      s_new = round_mul(longint'(py), InvGainCoef);
      acc = scaled_y_hist[0] + s_new + 4 * (scaled_y_hist[1] + scaled_y_hist[3])
          + 6 * scaled_y_hist[2]
          - round_mul(filt_y_hist[0], FbCoef0) - round_mul(filt_y_hist[1], FbCoef1)
          - round_mul(filt_y_hist[2], FbCoef2) - round_mul(filt_y_hist[3], FbCoef3);
      for (int i = 0; i < HistDepth - 1; i++) begin
        scaled_y_hist[i] = scaled_y_hist[i+1];
        filt_y_hist[i] = filt_y_hist[i+1];
      end
      scaled_y_hist[HistDepth-1] = clamp(s_new, S48Min, S48Max);
      filt_y_hist[HistDepth-1] = clamp(acc, S48Min, S48Max);
      if (acc > S32Max || acc < S32Min) filt_sats++;

      rate = (longint'(px) - last_x) * longint'(rate_hz);
      if (rate > S32Max || rate < S32Min) rate_sats++;
      rate = clamp(rate, S32Min, S32Max);
      vel = (rate + last_rate) / 2;  // truncates toward zero
      last_rate = rate;
      last_x = longint'(px);

      r.x = px;
      r.fy = q16_t'(clamp(acc, S32Min, S32Max));
      r.vx = q16_t'(vel);
      expected_poses.push_back(r);
    endfunction

    function void compare_field(input string name, input q16_t exp_v, input q16_t act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, name, exp_v, exp_v, act_v, act_v);
      end
    endfunction

    function void check_pose(input q16_t x, input q16_t fy, input q16_t vx);
      pose_t e;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: out_x=%0d filtered_y=%0d velocity_x=%0d",
                 $time, x, fy, vx);
        return;
      end
      e = expected_poses.pop_front();
      checked++;
      compare_field("out_x", e.x, x);
      compare_field("filtered_y", e.fy, fy);
      compare_field("velocity_x", e.vx, vx);
    endfunction
  endclass

endpackage

@@ tb/butterworth_lowpass_and_velocity_tb.sv @@
// Testbench top: drives position samples and sample-rate settings, checks every result.
module butterworth_lowpass_and_velocity_tb;
  import bwlv_tb_pkg::*;

  localparam q16_t PosMax = 32'sh7FFF_FFFF;
  localparam q16_t PosMin = 32'sh8000_0000;
  localparam int PhaseItems = 238;
  localparam int NumPhases = 8;
  localparam int LongHoldCycles = 300;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [bwlv_pkg::SrW-1:0]  cfg_wdata_i;

  bwlv_in_if  in_ch();
  bwlv_out_if out_ch();

  butterworth_lowpass_and_velocity #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  lowpass_velocity_scoreboard sb;

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int samples_sent;
  int rate_settings;
  int long_holds;
  int track_x;
  int track_y;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = 0;
      if (hold_req) begin
        stall = LongHoldCycles;
        hold_req = 1'b0;
        long_holds++;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_pose(out_ch.out_x, out_ch.filtered_y, out_ch.velocity_x);
  end

  // one input transaction; valid stays high into the next call unless a gap is taken
  task automatic send_sample(input q16_t px, input q16_t py);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(px, py);
    samples_sent++;
  endtask

  function automatic q16_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return PosMax;
      1:       return PosMin;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // mostly smooth trajectories, some raw noise, some extremes
  task automatic send_random();
    q16_t px;
    q16_t py;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      track_x = track_x + int'($urandom_range(0, 2097152)) - 1048576;
      track_y = track_y + int'($urandom_range(0, 2097152)) - 1048576;
      if ($urandom_range(0, 19) == 0) track_y = int'($urandom);
      if ($urandom_range(0, 49) == 0) track_x = int'($urandom);
      px = track_x;
      py = track_y;
    end else if (pick < 85) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = pick_extreme();
      py = pick_extreme();
    end
    send_sample(px, py);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_rate(input int unsigned r);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r[bwlv_pkg::SrW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_rate(r);
    rate_settings++;
  endtask

  initial begin
    int unsigned rate;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    track_x = 0;
    track_y = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes at the reset rate, velocity overflow both ways
    send_sample('0, '0);
    send_sample(PosMax, PosMax);
    send_sample(PosMin, PosMin);
    send_sample(PosMax, PosMax);
    send_sample(PosMin, PosMin);
    send_sample(-1, 1);
    send_sample(1, -1);
    // full-scale step on y: the overshoot drives the filter into saturation
    repeat (6) send_sample(32'sh0001_0000, PosMin);
    repeat (9) send_sample(32'sh0002_0000, PosMax);
    drain();
    // zero sample rate: the difference term drops out
    write_rate(0);
    send_sample(PosMin, '0);
    send_sample(PosMax, PosMin);
    send_sample(PosMin, PosMax);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       rate = 65535;
        1:       rate = 1;
        2:       rate = 100;
        3:       rate = 0;
        4:       rate = 30000;
        default: rate = $urandom_range(2, 65534);
      endcase
      write_rate(rate);
      tx_idle_en = (ph != 4) && (ph != NumPhases - 1);
      rx_idle_en = (ph != 4) && (ph != NumPhases - 1);
      if (ph == 2) hold_req = 1'b1;
      repeat (PhaseItems) send_random();
      drain();
    end

    $display("Sent %0d samples over %0d sample-rate settings, %0d results checked.",
             samples_sent, rate_settings, sb.checked);
    $display("Saturations seen: filter %0d, velocity %0d; long output hold-offs: %0d.",
             sb.filt_sats, sb.rate_sats, long_holds);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
